// File: rtl/core/assert_macros.svh
// assertion helpers used by the checker file irt_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/irt_pkg.sv
package irt_pkg;

    localparam int MAG_W          = 64;
    localparam int RADIX_W        = 5;
    localparam int DIGIT_W        = 4;
    localparam int CHAR_W         = 8;
    localparam int S_TDATA_W      = 72;
    localparam int M_TDATA_W      = 8;
    localparam int BITS_PER_CYCLE = 8;
    localparam int DIV_CYCLES     = MAG_W / BITS_PER_CYCLE;
    localparam int STEP_W         = $clog2(DIV_CYCLES);
    localparam int MAX_DIGITS_DEF = 24;

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(8);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER = 8'h61;

    // controller to datapath
    typedef struct packed {
        logic load;       // start a new number from the input transfer
        logic div_step;   // run one slice of the divider
        logic digit_wr;   // last slice: store remainder, take quotient
        logic idx_load;   // point the read index at the top digit
        logic idx_dec;    // step the read index down
        logic out_sign;   // load '-' into the output register
        logic out_digit;  // load the read digit into the output register
    } irt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic conv_done;  // the digit written now is the final one
        logic negative;
        logic idx_zero;
    } irt_stat_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] base_char;
        base_char = upper ? CHAR_UPPER : CHAR_LOWER;
        if (d < DIGIT_W'(10))
        begin
            digit_char = CHAR_ZERO + CHAR_W'(d);
        end
        else
        begin
            digit_char = base_char + CHAR_W'(d) - CHAR_W'(10);
        end
    endfunction

endpackage

// File: rtl/core/irt_ctrl.sv
module irt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  irt_pkg::irt_stat_t stat,
    output irt_pkg::irt_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SIGN = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_LD   = 3'd4;

    logic [2:0]                  state_reg, state_next;
    logic [irt_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign in_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == irt_pkg::STEP_W'(irt_pkg::DIV_CYCLES - 1))
                begin
                    cmd.digit_wr = 1'b1;
                    step_next    = '0;
                    if (stat.conv_done)
                    begin
                        state_next = S_SIGN;
                    end
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_SIGN:
            begin
                if (!stat.negative)
                begin
                    cmd.idx_load = 1'b1;
                    state_next   = S_RD;
                end
                else if (out_free)
                begin
                    cmd.out_sign = 1'b1;
                    cmd.idx_load = 1'b1;
                    state_next   = S_RD;
                end
            end
            S_RD:
            begin
                // memory read data lands at this edge
                state_next = S_LD;
            end
            S_LD:
            begin
                if (out_free)
                begin
                    cmd.out_digit = 1'b1;
                    if (stat.idx_zero)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_dec = 1'b1;
                        state_next  = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_sign || cmd.out_digit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/core/irt_dpath.sv
module irt_dpath #(
    parameter int MAX_DIGITS = irt_pkg::MAX_DIGITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [irt_pkg::MAG_W-1:0]    value,
    input  logic [irt_pkg::RADIX_W-1:0]  radix,
    input  logic                         upper_case,
    input  irt_pkg::irt_cmd_t            cmd,
    output irt_pkg::irt_stat_t           stat,
    output logic [irt_pkg::CHAR_W-1:0]   character,
    output logic                         last
);

    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    logic [irt_pkg::DIGIT_W-1:0] digit_mem [MAX_DIGITS];

    logic [irt_pkg::MAG_W-1:0]   mag_reg, mag_next;
    logic [irt_pkg::DIGIT_W-1:0] rem_reg, rem_next;
    logic [irt_pkg::RADIX_W-1:0] base_reg;
    logic                        neg_reg, upper_reg;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [IDX_W-1:0]            idx_reg;
    logic [irt_pkg::DIGIT_W-1:0] rd_reg;
    logic [irt_pkg::CHAR_W-1:0]  char_reg;
    logic                        last_reg;

    logic [irt_pkg::MAG_W-1:0]   q_work;
    logic [irt_pkg::RADIX_W-1:0] r_work;
    logic [irt_pkg::RADIX_W-1:0] trial;
    logic [irt_pkg::RADIX_W-1:0] base_in;

    always_comb
    begin
        if (radix < irt_pkg::RADIX_MIN)
        begin
            base_in = irt_pkg::RADIX_MIN;
        end
        else if (radix > irt_pkg::RADIX_MAX)
        begin
            base_in = irt_pkg::RADIX_MAX;
        end
        else
        begin
            base_in = radix;
        end
    end

    // one slice of restoring division by the base, msb first
    always_comb
    begin
        q_work = mag_reg;
        r_work = {1'b0, rem_reg};
        trial  = '0;
        for (int i = 0; i < irt_pkg::BITS_PER_CYCLE; i++)
        begin
            trial  = {r_work[irt_pkg::DIGIT_W-1:0], q_work[irt_pkg::MAG_W-1]};
            q_work = {q_work[irt_pkg::MAG_W-2:0], 1'b0};
            if (trial >= base_reg)
            begin
                r_work    = trial - base_reg;
                q_work[0] = 1'b1;
            end
            else
            begin
                r_work = trial;
            end
        end
    end

    always_comb
    begin
        mag_next   = mag_reg;
        rem_next   = rem_reg;
        count_next = count_reg;
        if (cmd.load)
        begin
            mag_next   = value[irt_pkg::MAG_W-1] ? (~value + 1'b1) : value;
            rem_next   = '0;
            count_next = '0;
        end
        else if (cmd.div_step)
        begin
            mag_next = q_work;
            rem_next = r_work[irt_pkg::DIGIT_W-1:0];
            if (cmd.digit_wr)
            begin
                rem_next   = '0;
                count_next = count_reg + 1'b1;
            end
        end
    end

    assign stat.conv_done = (q_work == '0) ||
                            ((count_reg + CNT_W'(1)) == CNT_W'(MAX_DIGITS));
    assign stat.negative  = neg_reg;
    assign stat.idx_zero  = (idx_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            mag_reg   <= '0;
            rem_reg   <= '0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            mag_reg   <= mag_next;
            rem_reg   <= rem_next;
            if (cmd.load)
            begin
                neg_reg <= value[irt_pkg::MAG_W-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_reg  <= base_in;
            upper_reg <= upper_case;
        end
        if (cmd.idx_load)
        begin
            idx_reg <= IDX_W'(count_reg - CNT_W'(1));
        end
        else if (cmd.idx_dec)
        begin
            idx_reg <= idx_reg - 1'b1;
        end
        if (cmd.out_sign)
        begin
            char_reg <= irt_pkg::CHAR_MINUS;
            last_reg <= 1'b0;
        end
        else if (cmd.out_digit)
        begin
            char_reg <= irt_pkg::digit_char(rd_reg, upper_reg);
            last_reg <= (idx_reg == '0);
        end
    end

    // digit store, least significant digit at address zero
    always_ff @(posedge clk)
    begin
        if (cmd.digit_wr)
        begin
            digit_mem[count_reg[IDX_W-1:0]] <= r_work[irt_pkg::DIGIT_W-1:0];
        end
        rd_reg <= digit_mem[idx_reg];
    end

    assign character = char_reg;
    assign last      = last_reg;

endmodule

// File: rtl/core/integer_to_radix_text_core.sv
// signed 64-bit integer to ascii text in base 8 to 16
//
// input channel s_*: one transfer carries one number (value, radix, upper_case).
// radix below 8 counts as 8, above 16 as 16. upper_case picks A-F or a-f.
// output channel m_*: one transfer per character, '-' first for a negative
// value, then digits most significant first; m_tlast marks the final digit.
// zero gives the single character '0'.
//
// conversion: a 64-bit restoring divider retiring 8 quotient bits per cycle makes one
// pass per digit, then a sign step, then for each character a registered digit store
// read followed by a load of the output register. the worst case is base 8 with 22
// digits. s_tready is high only between numbers, and may be high while the final
// character still waits in the output register.
// a stalled m_tready holds the character in the output register and freezes
// emission; the divider does not depend on the receiver.
// reset (rst_n low, asynchronous) empties the output register and returns to
// idle; the digit store needs no clearing.
module integer_to_radix_text_core #(
    parameter int MAX_DIGITS = irt_pkg::MAX_DIGITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [irt_pkg::S_TDATA_W-1:0]   s_tdata,   // value[63:0], radix[68:64], upper_case[69]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [irt_pkg::M_TDATA_W-1:0]   m_tdata,   // character[7:0]
    output logic                            m_tlast
);

    irt_pkg::irt_cmd_t  cmd;
    irt_pkg::irt_stat_t stat;

    irt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    irt_dpath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (s_tdata[irt_pkg::MAG_W-1:0]),
        .radix      (s_tdata[irt_pkg::MAG_W +: irt_pkg::RADIX_W]),
        .upper_case (s_tdata[irt_pkg::MAG_W + irt_pkg::RADIX_W]),
        .cmd        (cmd),
        .stat       (stat),
        .character  (m_tdata),
        .last       (m_tlast)
    );

endmodule

// File: rtl/core/irt_checker.sv
`include "assert_macros.svh"

module irt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [irt_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);

    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "output transfer dropped while stalled")
    `ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast), "stalled output changed")
    `ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second number taken during a conversion")
    `ASSERT_SAME(a_sign_not_last, m_tvalid && (m_tdata == irt_pkg::CHAR_MINUS), !m_tlast, "minus sign marked last")

endmodule

bind integer_to_radix_text_core irt_checker u_irt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
